// ===== hdl/ehm_pkg.sv =====
// ----------------------------------------------------------------------------
// Endstop hit monitor package
// Switch and axis bit positions, register indexes and the structs shared by
// the evaluation logic and the top level.
// ----------------------------------------------------------------------------
package ehm_pkg;

	localparam int SWITCH_COUNT = 14;
	localparam int AXIS_COUNT   = 4;
	localparam int HIT_BITS     = 7;
	localparam int ZCNT_W       = 3;
	localparam int CFG_IDX_W    = 2;
	localparam int MAX_Z        = 4;

	// switch bit positions
	localparam int SW_XMIN  = 0;
	localparam int SW_YMIN  = 1;
	localparam int SW_ZMIN  = 2;
	localparam int SW_PROBE = 3;
	localparam int SW_XMAX  = 4;
	localparam int SW_YMAX  = 5;
	localparam int SW_ZMAX  = 6;
	localparam int SW_Z2MIN = 7;
	localparam int SW_Z2MAX = 8;
	localparam int SW_EMIN  = 13;

	// axis bit positions
	localparam int AX_X = 0;
	localparam int AX_Y = 1;
	localparam int AX_Z = 2;
	localparam int AX_E = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Z_SWITCH_COUNT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_ON_ZMIN  = 2'd3;

	// item actions
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	typedef logic [SWITCH_COUNT-1:0] sw_vec_t;
	typedef logic [AXIS_COUNT-1:0]   ax_vec_t;

	typedef struct packed {
		logic    action;
		sw_vec_t pin_levels;
		ax_vec_t moving_axes;
		ax_vec_t negative_dirs;
		logic    homing;
		logic    probe_enabled;
		logic    target_probe_move;
	} item_t;

	typedef struct packed {
		sw_vec_t           invert_mask;
		sw_vec_t           present_mask;
		logic [ZCNT_W-1:0] z_switch_count;
		logic              probe_on_zmin;
	} cfg_t;

	typedef struct packed {
		sw_vec_t             sample_now;
		sw_vec_t             sample_prev;
		logic [HIT_BITS-1:0] hit_latch;
	} state_t;

	typedef struct packed {
		logic [HIT_BITS-1:0] hit_record;
		ax_vec_t             stop_axes;
		logic                kill_move;
		logic                probe_target_hit;
		sw_vec_t             confirmed_switches;
	} result_t;

endpackage

// ===== hdl/endstop_hit_monitor.sv =====
// ----------------------------------------------------------------------------
// Endstop hit monitor
// Limit-switch supervisor: confirms switches over two samples, latches hits
// and asks moving axes to stop or the move to be killed.
// ----------------------------------------------------------------------------
// Pipeline: input register, one combinational evaluation pass, result register.
// Throughput: one item per cycle while out_ready does not stall the result;
// switch state updates as each item leaves the input register, so consecutive
// items see each other's samples.
// Reset: config returns to invert 0, present 127, one Z switch, own probe pin;
// sample state and hit record clear; both pipeline stages empty.
module endstop_hit_monitor (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_wen,
	input  logic [ehm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ehm_pkg::SWITCH_COUNT-1:0]    cfg_data,

	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic [ehm_pkg::SWITCH_COUNT-1:0]    pin_levels,
	input  logic [ehm_pkg::AXIS_COUNT-1:0]      moving_axes,
	input  logic [ehm_pkg::AXIS_COUNT-1:0]      negative_dirs,
	input  logic                                homing,
	input  logic                                probe_enabled,
	input  logic                                target_probe_move,

	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ehm_pkg::HIT_BITS-1:0]        hit_record,
	output logic [ehm_pkg::AXIS_COUNT-1:0]      stop_axes,
	output logic                                kill_move,
	output logic                                probe_target_hit,
	output logic [ehm_pkg::SWITCH_COUNT-1:0]    confirmed_switches
);

	ehm_pkg::cfg_t    cfg_q;
	ehm_pkg::state_t  state_q;
	ehm_pkg::state_t  state_nxt;
	ehm_pkg::item_t   item_s1;
	logic             valid_s1;
	ehm_pkg::result_t res_nxt;
	ehm_pkg::result_t res_s2;
	logic             valid_s2;
	logic             advance;

	// move the item on when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.invert_mask    <= '0;
			cfg_q.present_mask   <= ehm_pkg::sw_vec_t'(127);
			cfg_q.z_switch_count <= 3'd1;
			cfg_q.probe_on_zmin  <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				ehm_pkg::REG_INVERT_MASK:    cfg_q.invert_mask    <= cfg_data;
				ehm_pkg::REG_PRESENT_MASK:   cfg_q.present_mask   <= cfg_data;
				ehm_pkg::REG_Z_SWITCH_COUNT: cfg_q.z_switch_count <= cfg_data[ehm_pkg::ZCNT_W-1:0];
				ehm_pkg::REG_PROBE_ON_ZMIN:  cfg_q.probe_on_zmin  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers: hold while stalled
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.action            <= action;
			item_s1.pin_levels        <= pin_levels;
			item_s1.moving_axes       <= moving_axes;
			item_s1.negative_dirs     <= negative_dirs;
			item_s1.homing            <= homing;
			item_s1.probe_enabled     <= probe_enabled;
			item_s1.target_probe_move <= target_probe_move;
		end
		if (advance)
			res_s2 <= res_nxt;
	end

	ehm_eval u_eval (
		.item (item_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign out_valid          = valid_s2;
	assign hit_record         = res_s2.hit_record;
	assign stop_axes          = res_s2.stop_axes;
	assign kill_move          = res_s2.kill_move;
	assign probe_target_hit   = res_s2.probe_target_hit;
	assign confirmed_switches = res_s2.confirmed_switches;

endmodule

// ===== hdl/ehm_eval.sv =====
// ----------------------------------------------------------------------------
// Endstop hit monitor evaluation
// Combinational pass for one item: resample the switches that face a moving
// axis, confirm against the previous sample, latch or clear hits, build the result.
// ----------------------------------------------------------------------------
module ehm_eval (
	input  ehm_pkg::item_t   item,
	input  ehm_pkg::cfg_t    cfg,
	input  ehm_pkg::state_t  cur,
	output ehm_pkg::state_t  nxt,
	output ehm_pkg::result_t res
);

	always_comb begin
		ehm_pkg::sw_vec_t              pe;
		ehm_pkg::sw_vec_t              sn;
		ehm_pkg::sw_vec_t              prev;
		logic [ehm_pkg::HIT_BITS-1:0]  hit;
		ehm_pkg::ax_vec_t              stop;
		logic                          kill;
		logic                          thit;
		logic                          own_probe;
		logic [ehm_pkg::ZCNT_W-1:0]    cnt;
		logic [ehm_pkg::MAX_Z-1:0]     zmask;
		logic [ehm_pkg::MAX_Z-1:0]     test;
		logic                          do_multi;
		logic [3:0]                    zbase;
		logic [3:0]                    zext;
		logic [3:0]                    zb;
		logic [3:0]                    ab;
		logic                          zval;

		pe        = item.pin_levels ^ cfg.invert_mask;
		sn        = cur.sample_now;
		prev      = cur.sample_prev;
		hit       = cur.hit_latch;
		stop      = '0;
		kill      = 1'b0;
		thit      = 1'b0;
		own_probe = cfg.present_mask[ehm_pkg::SW_PROBE] & ~cfg.probe_on_zmin;
		do_multi  = 1'b0;
		zbase     = 4'(ehm_pkg::SW_ZMIN);
		zext      = 4'(ehm_pkg::SW_Z2MIN);
		test      = '0;
		zb        = '0;
		ab        = '0;
		zval      = 1'b0;

		// clamp the joint Z count to 1..4
		if (cfg.z_switch_count == 3'd0)
			cnt = 3'd1;
		else if (cfg.z_switch_count > 3'd4)
			cnt = 3'd4;
		else
			cnt = cfg.z_switch_count;
		zmask = 4'hF >> (3'd4 - cnt);

		if (item.action == ehm_pkg::ACT_CLEAR) begin
			hit = '0;
		end else begin
			// probe-to-target move: probe stops the first moving axis
			if (item.target_probe_move && own_probe) begin
				sn[ehm_pkg::SW_PROBE] = pe[ehm_pkg::SW_PROBE];
				if (pe[ehm_pkg::SW_PROBE] && prev[ehm_pkg::SW_PROBE]) begin
					thit = 1'b1;
					if (item.moving_axes[ehm_pkg::AX_X]) begin
						hit[ehm_pkg::SW_XMIN] = 1'b1;
						stop[ehm_pkg::AX_X]   = 1'b1;
					end else if (item.moving_axes[ehm_pkg::AX_Y]) begin
						hit[ehm_pkg::SW_YMIN] = 1'b1;
						stop[ehm_pkg::AX_Y]   = 1'b1;
					end else if (item.moving_axes[ehm_pkg::AX_Z]) begin
						hit[ehm_pkg::SW_ZMIN] = 1'b1;
						stop[ehm_pkg::AX_Z]   = 1'b1;
					end
				end
			end

			// X and Y: min or max switch by direction
			for (int a = ehm_pkg::AX_X; a <= ehm_pkg::AX_Y; a++) begin
				ab = item.negative_dirs[a] ? 4'(a) : 4'(a + ehm_pkg::SW_XMAX);
				if (item.moving_axes[a] && cfg.present_mask[ab]) begin
					sn[ab] = pe[ab];
					if (pe[ab] && prev[ab]) begin
						hit[ab[2:0]] = 1'b1;
						stop[a]      = 1'b1;
					end
				end
			end

			if (item.moving_axes[ehm_pkg::AX_Z]) begin
				if (item.negative_dirs[ehm_pkg::AX_Z]) begin
					if (cfg.present_mask[ehm_pkg::SW_ZMIN]) begin
						if (cnt >= 3'd2) begin
							do_multi = 1'b1;
						end else if (!cfg.probe_on_zmin || item.probe_enabled) begin
							sn[ehm_pkg::SW_ZMIN] = pe[ehm_pkg::SW_ZMIN];
							if (pe[ehm_pkg::SW_ZMIN] && prev[ehm_pkg::SW_ZMIN]) begin
								hit[ehm_pkg::SW_ZMIN] = 1'b1;
								stop[ehm_pkg::AX_Z]   = 1'b1;
							end
						end
					end
					if (own_probe && item.probe_enabled) begin
						sn[ehm_pkg::SW_PROBE] = pe[ehm_pkg::SW_PROBE];
						if (pe[ehm_pkg::SW_PROBE] && prev[ehm_pkg::SW_PROBE]) begin
							hit[ehm_pkg::SW_PROBE] = 1'b1;
							stop[ehm_pkg::AX_Z]    = 1'b1;
						end
					end
				end else if (cfg.present_mask[ehm_pkg::SW_ZMAX]) begin
					if (cnt >= 3'd2) begin
						do_multi = 1'b1;
						zbase    = 4'(ehm_pkg::SW_ZMAX);
						zext     = 4'(ehm_pkg::SW_Z2MAX);
					end else begin
						sn[ehm_pkg::SW_ZMAX] = pe[ehm_pkg::SW_ZMAX];
						if (pe[ehm_pkg::SW_ZMAX] && prev[ehm_pkg::SW_ZMAX]) begin
							hit[ehm_pkg::SW_ZMAX] = 1'b1;
							stop[ehm_pkg::AX_Z]   = 1'b1;
						end
					end
				end
			end

			// joint Z test; an absent extra switch copies the main one
			if (do_multi) begin
				sn[zbase] = pe[zbase];
				test[0]   = pe[zbase] & prev[zbase];
				for (int k = 1; k < ehm_pkg::MAX_Z; k++) begin
					zb = zext + 4'(2 * (k - 1));
					if (3'(k) < cnt) begin
						zval    = cfg.present_mask[zb] ? pe[zb] : pe[zbase];
						sn[zb]  = zval;
						test[k] = zval & prev[zb];
					end
				end
				if (test != '0) begin
					hit[ehm_pkg::SW_ZMIN] = 1'b1;
					if (!item.homing || test == zmask)
						kill = 1'b1;
				end
			end

			// extruder switch stops e but is never latched
			if (cfg.present_mask[ehm_pkg::SW_EMIN]) begin
				sn[ehm_pkg::SW_EMIN] = pe[ehm_pkg::SW_EMIN];
				if (pe[ehm_pkg::SW_EMIN] && prev[ehm_pkg::SW_EMIN]
				    && item.moving_axes[ehm_pkg::AX_E])
					stop[ehm_pkg::AX_E] = 1'b1;
			end
		end

		if (item.action == ehm_pkg::ACT_CLEAR) begin
			nxt.sample_now  = cur.sample_now;
			nxt.sample_prev = cur.sample_prev;
		end else begin
			nxt.sample_now  = sn;
			nxt.sample_prev = sn;
		end
		nxt.hit_latch = hit;

		res.hit_record         = hit;
		res.stop_axes          = stop;
		res.kill_move          = kill;
		res.probe_target_hit   = thit;
		res.confirmed_switches = sn & prev;
	end

endmodule

// ===== tb/endstop_hit_monitor_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Endstop hit monitor checker
// Follows register writes and input transfers, predicts each result from its
// own copy of the switch state and settings, and compares every result
// transfer field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module endstop_hit_monitor_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [ehm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ehm_pkg::SWITCH_COUNT-1:0] cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic                             action,
	input  ehm_pkg::sw_vec_t                 pin_levels,
	input  ehm_pkg::ax_vec_t                 moving_axes,
	input  ehm_pkg::ax_vec_t                 negative_dirs,
	input  logic                             homing,
	input  logic                             probe_enabled,
	input  logic                             target_probe_move,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [ehm_pkg::HIT_BITS-1:0]     hit_record,
	input  ehm_pkg::ax_vec_t                 stop_axes,
	input  logic                             kill_move,
	input  logic                             probe_target_hit,
	input  ehm_pkg::sw_vec_t                 confirmed_switches,
	output int                               fail_count,
	output int                               pending
);

	ehm_pkg::sw_vec_t             cfg_invert;
	ehm_pkg::sw_vec_t             cfg_present;
	logic [ehm_pkg::ZCNT_W-1:0]   cfg_zcount;
	logic                         cfg_probe_on_zmin;

	ehm_pkg::sw_vec_t             sw_now;
	ehm_pkg::sw_vec_t             sw_prev;
	logic [ehm_pkg::HIT_BITS-1:0] hit_latch_q;

	// working values of the tick being evaluated
	ehm_pkg::sw_vec_t             work_pins;
	ehm_pkg::sw_vec_t             work_prev;

	ehm_pkg::result_t             awaited_results[$];
	ehm_pkg::result_t             want;
	ehm_pkg::item_t               seen_item;
	int                           errors = 0;

	function automatic logic resample(int b);
		sw_now[b] = work_pins[b];
		return sw_now[b] & work_prev[b];
	endfunction

	// joint test of the Z switches on one side; returns the kill request
	function automatic logic joint_z_kill(int base, int extra0, int cnt, logic is_homing);
		logic [ehm_pkg::MAX_Z-1:0] z_hits;
		int                        b;
		z_hits = '0;
		z_hits[0] = resample(base);
		for (int k = 1; k < cnt; k++) begin
			b = extra0 + 2 * (k - 1);
			if (cfg_present[b]) begin
				z_hits[k] = resample(b);
			end else begin
				// a missing extra switch follows the main one
				sw_now[b] = sw_now[base];
				z_hits[k] = sw_now[b] & work_prev[b];
			end
		end
		if (z_hits == '0)
			return 1'b0;
		hit_latch_q[ehm_pkg::SW_ZMIN] = 1'b1;
		return !is_homing || int'(z_hits) == (1 << cnt) - 1;
	endfunction

	function automatic ehm_pkg::result_t evaluate_endstops(ehm_pkg::item_t it);
		ehm_pkg::result_t r;
		logic             own_probe;
		int               zcnt;
		int               b;
		r = '0;
		own_probe = cfg_present[ehm_pkg::SW_PROBE] && !cfg_probe_on_zmin;
		if (it.action == ehm_pkg::ACT_CLEAR) begin
			hit_latch_q = '0;
			r.confirmed_switches = sw_now & sw_prev;
			return r;
		end
		if (cfg_zcount == 0)
			zcnt = 1;
		else if (cfg_zcount > ehm_pkg::MAX_Z)
			zcnt = ehm_pkg::MAX_Z;
		else
			zcnt = int'(cfg_zcount);
		work_pins = it.pin_levels ^ cfg_invert;
		work_prev = sw_prev;

		if (it.target_probe_move && own_probe) begin
			if (resample(ehm_pkg::SW_PROBE)) begin
				r.probe_target_hit = 1'b1;
				if (it.moving_axes[ehm_pkg::AX_X]) begin
					hit_latch_q[ehm_pkg::SW_XMIN] = 1'b1;
					r.stop_axes[ehm_pkg::AX_X] = 1'b1;
				end else if (it.moving_axes[ehm_pkg::AX_Y]) begin
					hit_latch_q[ehm_pkg::SW_YMIN] = 1'b1;
					r.stop_axes[ehm_pkg::AX_Y] = 1'b1;
				end else if (it.moving_axes[ehm_pkg::AX_Z]) begin
					hit_latch_q[ehm_pkg::SW_ZMIN] = 1'b1;
					r.stop_axes[ehm_pkg::AX_Z] = 1'b1;
				end
			end
		end

		for (int a = ehm_pkg::AX_X; a <= ehm_pkg::AX_Y; a++) begin
			if (it.moving_axes[a]) begin
				b = it.negative_dirs[a] ? ehm_pkg::SW_XMIN + a : ehm_pkg::SW_XMAX + a;
				if (cfg_present[b]) begin
					if (resample(b)) begin
						hit_latch_q[b] = 1'b1;
						r.stop_axes[a] = 1'b1;
					end
				end
			end
		end

		if (it.moving_axes[ehm_pkg::AX_Z]) begin
			if (it.negative_dirs[ehm_pkg::AX_Z]) begin
				if (cfg_present[ehm_pkg::SW_ZMIN]) begin
					if (zcnt >= 2) begin
						if (joint_z_kill(ehm_pkg::SW_ZMIN, ehm_pkg::SW_Z2MIN, zcnt,
								it.homing))
							r.kill_move = 1'b1;
					end else if (!cfg_probe_on_zmin || it.probe_enabled) begin
						if (resample(ehm_pkg::SW_ZMIN)) begin
							hit_latch_q[ehm_pkg::SW_ZMIN] = 1'b1;
							r.stop_axes[ehm_pkg::AX_Z] = 1'b1;
						end
					end
				end
				if (own_probe && it.probe_enabled) begin
					if (resample(ehm_pkg::SW_PROBE)) begin
						hit_latch_q[ehm_pkg::SW_PROBE] = 1'b1;
						r.stop_axes[ehm_pkg::AX_Z] = 1'b1;
					end
				end
			end else if (cfg_present[ehm_pkg::SW_ZMAX]) begin
				if (zcnt >= 2) begin
					if (joint_z_kill(ehm_pkg::SW_ZMAX, ehm_pkg::SW_Z2MAX, zcnt, it.homing))
						r.kill_move = 1'b1;
				end else if (resample(ehm_pkg::SW_ZMAX)) begin
					hit_latch_q[ehm_pkg::SW_ZMAX] = 1'b1;
					r.stop_axes[ehm_pkg::AX_Z] = 1'b1;
				end
			end
		end

		// extruder switch stops e but has no place in the hit record
		if (cfg_present[ehm_pkg::SW_EMIN]) begin
			if (resample(ehm_pkg::SW_EMIN) && it.moving_axes[ehm_pkg::AX_E])
				r.stop_axes[ehm_pkg::AX_E] = 1'b1;
		end

		sw_prev = sw_now;
		r.hit_record = hit_latch_q;
		r.confirmed_switches = sw_now & work_prev;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (got_val !== exp_val) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, got_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_invert = '0;
			cfg_present = ehm_pkg::sw_vec_t'(127);
			cfg_zcount = 3'd1;
			cfg_probe_on_zmin = 1'b0;
			sw_now = '0;
			sw_prev = '0;
			hit_latch_q = '0;
			awaited_results.delete();
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					ehm_pkg::REG_INVERT_MASK:    cfg_invert = cfg_data;
					ehm_pkg::REG_PRESENT_MASK:   cfg_present = cfg_data;
					ehm_pkg::REG_Z_SWITCH_COUNT: cfg_zcount = cfg_data[ehm_pkg::ZCNT_W-1:0];
					ehm_pkg::REG_PROBE_ON_ZMIN:  cfg_probe_on_zmin = cfg_data[0];
					default: ;
				endcase
			end
			// retire before predicting: a result never belongs to this edge's input
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result: hit %h stop %h kill %b target %b conf %h",
						$time, hit_record, stop_axes, kill_move, probe_target_hit,
						confirmed_switches);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					compare_field("hit_record", 32'(want.hit_record), 32'(hit_record));
					compare_field("stop_axes", 32'(want.stop_axes), 32'(stop_axes));
					compare_field("kill_move", 32'(want.kill_move), 32'(kill_move));
					compare_field("probe_target_hit", 32'(want.probe_target_hit),
						32'(probe_target_hit));
					compare_field("confirmed_switches", 32'(want.confirmed_switches),
						32'(confirmed_switches));
				end
			end
			if (in_valid && in_ready) begin
				seen_item.action = action;
				seen_item.pin_levels = pin_levels;
				seen_item.moving_axes = moving_axes;
				seen_item.negative_dirs = negative_dirs;
				seen_item.homing = homing;
				seen_item.probe_enabled = probe_enabled;
				seen_item.target_probe_move = target_probe_move;
				awaited_results.push_back(evaluate_endstops(seen_item));
			end
		end
		pending <= awaited_results.size();
		fail_count <= errors;
	end

endmodule

// ===== tb/endstop_hit_monitor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Endstop hit monitor testbench
// Runs the block through a series of switch settings; each setting gets a
// short fixed burst then random switch scenes held for one to six items,
// with random gaps on the sending and receiving side in all but the last two.
// ----------------------------------------------------------------------------
module endstop_hit_monitor_tb;

	localparam int PHASES       = 7;
	localparam int RANDOM_ITEMS = 58;
	localparam int STALL_LIMIT  = 2000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_wen = 1'b0;
	logic [ehm_pkg::CFG_IDX_W-1:0] cfg_index = ehm_pkg::REG_INVERT_MASK;
	ehm_pkg::sw_vec_t              cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          action = ehm_pkg::ACT_SAMPLE;
	ehm_pkg::sw_vec_t              pin_levels = '0;
	ehm_pkg::ax_vec_t              moving_axes = '0;
	ehm_pkg::ax_vec_t              negative_dirs = '0;
	logic                          homing = 1'b0;
	logic                          probe_enabled = 1'b0;
	logic                          target_probe_move = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [ehm_pkg::HIT_BITS-1:0]  hit_record;
	ehm_pkg::ax_vec_t              stop_axes;
	logic                          kill_move;
	logic                          probe_target_hit;
	ehm_pkg::sw_vec_t              confirmed_switches;

	int                            fail_count;
	int                            pending;
	int                            send_idle_pct = 0;
	int                            recv_idle_pct = 0;
	int                            quiet_cycles = 0;
	ehm_pkg::cfg_t                 settings [PHASES];

	endstop_hit_monitor dut (.*);

	endstop_hit_monitor_checker u_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_item(input ehm_pkg::item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.action;
		pin_levels <= it.pin_levels;
		moving_axes <= it.moving_axes;
		negative_dirs <= it.negative_dirs;
		homing <= it.homing;
		probe_enabled <= it.probe_enabled;
		target_probe_move <= it.target_probe_move;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid and wait until every predicted result has come out
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(input ehm_pkg::cfg_t c);
		cfg_wen <= 1'b1;
		cfg_index <= ehm_pkg::REG_INVERT_MASK;
		cfg_data <= c.invert_mask;
		@(posedge clk);
		cfg_index <= ehm_pkg::REG_PRESENT_MASK;
		cfg_data <= c.present_mask;
		@(posedge clk);
		cfg_index <= ehm_pkg::REG_Z_SWITCH_COUNT;
		cfg_data <= ehm_pkg::sw_vec_t'(c.z_switch_count);
		@(posedge clk);
		cfg_index <= ehm_pkg::REG_PROBE_ON_ZMIN;
		cfg_data <= ehm_pkg::sw_vec_t'(c.probe_on_zmin);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	initial begin
		ehm_pkg::item_t it;
		ehm_pkg::item_t scene;
		ehm_pkg::cfg_t  cur;
		logic [31:0]    raw;
		int             run_left;
		int             roll;
		int             k;

		// first entry is the reset state, left unwritten
		settings[0] = '{14'h0000, 14'h007f, 3'd1, 1'b0};
		settings[1] = '{14'h3fff, 14'h3fff, 3'd4, 1'b0};
		settings[2] = '{14'h0000, 14'h007f, 3'd3, 1'b0};
		settings[3] = '{14'h2aaa, 14'h3ff7, 3'd0, 1'b1};
		settings[4] = '{14'h1555, 14'h3fff, 3'd7, 1'b1};
		settings[5] = '{14'h0000, 14'h0000, 3'd2, 1'b0};
		settings[6] = '{14'h3fff, 14'h20ff, 3'd2, 1'b1};
		scene = '0;
		run_left = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase < 3) begin
				send_idle_pct = 25;
				recv_idle_pct = 73;
			end else if (phase < 5) begin
				send_idle_pct = 73;
				recv_idle_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (phase != 0) begin
				settle();
				apply_settings(settings[phase]);
			end
			cur = settings[phase];

			// every switch active, all axes towards minimum, twice to confirm
			it = '0;
			it.action = ehm_pkg::ACT_SAMPLE;
			it.pin_levels = ~cur.invert_mask;
			it.moving_axes = '1;
			it.negative_dirs = '1;
			it.homing = 1'b1;
			it.probe_enabled = 1'b1;
			it.target_probe_move = 1'b1;
			send_item(it);
			send_item(it);
			// probe-to-target move with nothing moving
			it.moving_axes = '0;
			it.negative_dirs = '0;
			it.homing = 1'b0;
			send_item(it);
			it = '0;
			it.action = ehm_pkg::ACT_CLEAR;
			send_item(it);

			for (int n = 0; n < RANDOM_ITEMS; n++) begin
				if (run_left == 0) begin
					scene.action = ehm_pkg::ACT_SAMPLE;
					case ($urandom_range(3))
						0: scene.pin_levels = ~cur.invert_mask;
						1: scene.pin_levels = cur.invert_mask;
						default: scene.pin_levels = ehm_pkg::sw_vec_t'($urandom);
					endcase
					scene.moving_axes = ehm_pkg::ax_vec_t'($urandom);
					scene.negative_dirs = ehm_pkg::ax_vec_t'($urandom);
					scene.homing = 1'($urandom_range(1));
					scene.probe_enabled = 1'($urandom_range(1));
					scene.target_probe_move = 1'($urandom_range(1));
					run_left = $urandom_range(1, 6);
				end
				it = scene;
				roll = $urandom_range(99);
				if (roll < 6) begin
					it.action = ehm_pkg::ACT_CLEAR;
				end else if (roll < 14) begin
					raw = $urandom;
					it = raw[$bits(ehm_pkg::item_t)-1:0];
				end else if (roll < 30) begin
					// toggle one switch and keep it for the rest of the scene
					k = $urandom_range(ehm_pkg::SWITCH_COUNT - 1);
					it.pin_levels[k] = ~it.pin_levels[k];
					scene.pin_levels = it.pin_levels;
				end
				send_item(it);
				run_left--;
			end
		end

		settle();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
